FILE: src/fifo_queue_with_keyed_removal_unit_macros.svh
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FQR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fqr check failed");

// next-cycle implication, checked out of reset
`define FQR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fqr check failed");

`endif

FILE: src/fqr_pkg.sv
package fqr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_REMOVE  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic more;
    } cmp_res_t;

endpackage

FILE: src/fqr_store.sv
module fqr_store #(
    parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  fqr_pkg::entry_t wr_data,
    input  logic [IW-1:0]   rd_addr,
    output fqr_pkg::entry_t rd_data
);

    fqr_pkg::entry_t mem [QUEUE_DEPTH];
    fqr_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/fqr_cmp.sv
module fqr_cmp #(
    parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic [fqr_pkg::ID_W-1:0] slot_id,
    input  logic [fqr_pkg::ID_W-1:0] key,
    input  logic                     take_any,
    input  logic [IW-1:0]            idx,
    input  logic [CW-1:0]            count,
    output fqr_pkg::cmp_res_t        res
);

    always_comb begin
        res.hit  = take_any || (slot_id == key);
        res.more = (CW'(idx) + CW'(1)) < count;
    end

endmodule

FILE: src/fifo_queue_with_keyed_removal_unit.sv
// Process ready queue, FIFO order, with removal of the first entry by id.
// Input stream (s_): s_tuser carries the request (enqueue, dequeue, remove),
// s_tdata the id and handle. One result word per request on m_.
// Entries live in a single-port-write, registered-read RAM with the head at
// slot 0; one id comparator is stepped over the slots by a small sequencer.
// Enqueue, full, empty and unused requests go from accept straight to the
// output state. Dequeue and remove walk every slot below the count, each
// slot taking a RAM read state, then a compare or shift-down write state,
// before the output state. No new request is taken until the current one
// has left the output state.
// One request is in flight at a time; s_tready is high only while idle.
// The result sits in an output register; if the receiver stalls, one further
// request is accepted and processed, then the block holds its word and
// accepts nothing more until the waiting word is taken.
// Reset empties the queue and clears m_tvalid; RAM contents are left as is,
// no clearing pass is needed since only slots below the count are read.
module fifo_queue_with_keyed_removal_unit #(
    parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // proc_id[15:0], proc_handle[47:16]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], out_id[17:2], out_handle[49:18], occupancy[54:50], is_empty[55]
    output logic [55:0] m_tdata
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [fqr_pkg::ID_W-1:0]        key_reg, key_next;
    logic                            any_reg, any_next;
    logic                            shift_reg, shift_next;
    fqr_pkg::status_t                status_reg, status_next;
    fqr_pkg::entry_t                 ent_reg, ent_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [55:0]                     m_tdata_reg, m_tdata_next;

    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    fqr_pkg::entry_t                 wr_data;
    fqr_pkg::entry_t                 rd_data;
    fqr_pkg::cmp_res_t               cmp;
    logic [fqr_pkg::REQ_W-1:0]       req;

    assign req = s_tuser;

    fqr_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    fqr_cmp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cmp (
        .slot_id  (rd_data.id),
        .key      (key_reg),
        .take_any (any_reg),
        .idx      (idx_reg),
        .count    (count_reg),
        .res      (cmp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        any_next      = any_reg;
        shift_next    = shift_reg;
        status_next   = status_reg;
        ent_next      = ent_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = rd_data;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next    = s_tdata[15:0];
                    any_next    = (req == fqr_pkg::REQ_DEQUEUE);
                    shift_next  = 1'b0;
                    idx_next    = '0;
                    ent_next    = '0;
                    status_next = fqr_pkg::ST_NONE;
                    state_next  = S_OUT;
                    case (req)
                        fqr_pkg::REQ_ENQUEUE: begin
                            if (count_reg == CW'(QUEUE_DEPTH)) begin
                                status_next = fqr_pkg::ST_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                wr_addr        = count_reg[IW-1:0];
                                wr_data.id     = s_tdata[15:0];
                                wr_data.handle = s_tdata[47:16];
                                count_next     = count_reg + CW'(1);
                                status_next    = fqr_pkg::ST_DONE;
                            end
                        end
                        fqr_pkg::REQ_DEQUEUE, fqr_pkg::REQ_REMOVE: begin
                            if (count_reg != '0) begin
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (shift_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - IW'(1);
                    wr_data = rd_data;
                    if (cmp.more) begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_OUT;
                    end
                end else if (cmp.hit) begin
                    ent_next    = rd_data;
                    status_next = fqr_pkg::ST_DONE;
                    if (cmp.more) begin
                        idx_next   = idx_reg + IW'(1);
                        shift_next = 1'b1;
                        state_next = S_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_OUT;
                    end
                end else if (cmp.more) begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(count_reg == '0), fqr_pkg::OCC_W'(count_reg),
                                     ent_reg.handle, ent_reg.id, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        any_reg     <= any_next;
        shift_reg   <= shift_next;
        status_reg  <= status_next;
        ent_reg     <= ent_next;
        m_tdata_reg <= m_tdata_next;
    end

`include "fifo_queue_with_keyed_removal_unit_macros.svh"

    `FQR_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `FQR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `FQR_ASSERT_NOW(a_zero_when_none, aclk, aresetn,
        m_tvalid_reg && (m_tdata_reg[1:0] != fqr_pkg::ST_DONE),
        m_tdata_reg[49:2] == '0)
    `FQR_ASSERT_NEXT(a_count_step, aclk, aresetn, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) ||
        (count_reg == $past(count_reg) - CW'(1)))

endmodule
